/* rtl/core/mlts_pkg.sv */
package mlts_pkg;

    localparam int SEQ_DEPTH_DEF = 128;
    localparam int GAP_MS_DEF    = 10;

    localparam int TL_W    = 17;
    localparam int BEAT_W  = 9;
    localparam int BYTE_W  = 8;
    localparam int REQ_W   = 2;
    localparam int PER_W   = 12;

    localparam logic [BYTE_W-1:0] CMD_NOTES = 8'h4E;
    localparam logic [BYTE_W-1:0] CMD_DURS  = 8'h44;
    localparam logic [BYTE_W-1:0] CMD_END   = 8'h7F;
    localparam logic [BYTE_W-1:0] CMD_PLAY  = 8'h50;
    localparam logic [BYTE_W-1:0] CMD_STOP  = 8'h53;
    localparam logic [BYTE_W-1:0] CMD_BEAT  = 8'h54;

    localparam int BEAT_CODES = 5;
    localparam int TONE_COUNT = 14;
    localparam int US_PER_S   = 1000000;
    localparam logic [BEAT_W-1:0] BEAT_RESET = 9'd250;

    typedef enum logic [REQ_W-1:0] {
        REQ_BYTE   = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_BUTTON = 2'd2
    } t_req;

    localparam int BEAT_0 = 500 * 60 / 60;
    localparam int BEAT_1 = 500 * 60 / 80;
    localparam int BEAT_2 = 500 * 60 / 100;
    localparam int BEAT_3 = 500 * 60 / 120;
    localparam int BEAT_4 = 500 * 60 / 200;

    localparam logic [PER_W-1:0] TONE_PERIOD [TONE_COUNT] = '{
        12'(US_PER_S / 262), 12'(US_PER_S / 293), 12'(US_PER_S / 329),
        12'(US_PER_S / 349), 12'(US_PER_S / 392), 12'(US_PER_S / 440),
        12'(US_PER_S / 494), 12'(US_PER_S / 523), 12'(US_PER_S / 587),
        12'(US_PER_S / 659), 12'(US_PER_S / 698), 12'(US_PER_S / 784),
        12'(US_PER_S / 880), 12'(US_PER_S / 988)
    };

    function automatic logic [BEAT_W-1:0] beat_of_code(input logic [2:0] code);
        logic [BEAT_W-1:0] ms;
        case (code)
            3'd0:    ms = BEAT_W'(BEAT_0);
            3'd1:    ms = BEAT_W'(BEAT_1);
            3'd2:    ms = BEAT_W'(BEAT_2);
            3'd3:    ms = BEAT_W'(BEAT_3);
            3'd4:    ms = BEAT_W'(BEAT_4);
            default: ms = BEAT_RESET;
        endcase
        return ms;
    endfunction

    function automatic logic [PER_W-1:0] period_of_code(input logic [3:0] code);
        logic [PER_W-1:0] per;
        if (code < 4'(TONE_COUNT)) begin
            per = TONE_PERIOD[code];
        end else begin
            per = '0;
        end
        return per;
    endfunction

endpackage

/* rtl/core/mlts_if.sv */
interface mlts_in_if;
    logic                          valid;
    logic                          ready;
    logic [mlts_pkg::REQ_W-1:0]    req_type;
    logic [mlts_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, req_type, rx_byte, input ready);
    modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

interface mlts_out_if;
    logic                          valid;
    logic                          ready;
    logic                          tone_on;
    logic [mlts_pkg::PER_W-1:0]    tone_period;
    logic                          playing;

    modport source (output valid, tone_on, tone_period, playing, input ready);
    modport sink   (input valid, tone_on, tone_period, playing, output ready);
endinterface

/* rtl/core/melody_loader_and_tone_sequencer.sv */
// Channel  Dir  Payload                              Handshake
// i_in     in   req_type[1:0], rx_byte[7:0]          valid/ready
// o_out    out  tone_on, tone_period[11:0], playing  valid/ready
//
// One result per accepted item; a new item may be accepted every cycle while the output is not stalled.
// Each item passes the input register, the state update with the store read,
// then the tone lookup into the output register.
// The registered read of the note and duration stores sets the second stage.
// Reset is synchronous; the store valid bits clear at once, no sweep needed.
// Each stage moves when the one after it is empty or moving, so a stalled
// output still lets the earlier stages fill.
module melody_loader_and_tone_sequencer #(
    parameter int SEQ_DEPTH = mlts_pkg::SEQ_DEPTH_DEF,
    parameter int GAP_MS    = mlts_pkg::GAP_MS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mlts_in_if.sink           i_in,
    mlts_out_if.source        o_out
);

    localparam int AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
    localparam int LW = $clog2(SEQ_DEPTH + 1);
    localparam int CW = AW + 1;
    localparam int TW = mlts_pkg::TL_W;
    localparam int BW = mlts_pkg::BYTE_W;

    // Stage one: input register.
    logic                        r_s1_vld;
    logic [mlts_pkg::REQ_W-1:0]  r_s1_req;
    logic [BW-1:0]               r_s1_byte;

    // Sequencer state.
    logic [LW-1:0]               r_load_idx, n_load_idx;
    logic [LW-1:0]               r_mel_len, n_mel_len;
    logic [AW-1:0]               r_play_idx, n_play_idx;
    logic                        r_active, n_active;
    logic                        r_load_notes, n_load_notes;
    logic                        r_load_lens, n_load_lens;
    logic                        r_beat_pend, n_beat_pend;
    logic [mlts_pkg::BEAT_W-1:0] r_beat_ms, n_beat_ms;
    logic [TW-1:0]               r_time_left, n_time_left;
    logic                        r_in_gap, n_in_gap;
    logic                        r_tl_pend, n_tl_pend;
    logic [SEQ_DEPTH-1:0]        r_note_vld;
    logic [SEQ_DEPTH-1:0]        r_len_vld;
    logic                        r_len_vld_q;

    // Stage two: state snapshot beside the registered store reads.
    logic                        r_s2_vld;
    logic                        r_s2_active;
    logic                        r_s2_gap;
    logic                        r_s2_byp;
    logic [BW-1:0]               r_s2_byp_code;
    logic                        r_s2_note_vld;

    // Output register.
    logic                        r_out_vld;
    logic                        r_out_tone_on;
    logic [mlts_pkg::PER_W-1:0]  r_out_period;
    logic                        r_out_playing;

    logic                        adv_out, adv_s2, adv_s1, step;
    logic                        do_start, do_stop, do_load, adv_note;
    logic                        wr_note, wr_len;
    logic [TW-1:0]               tl_eff, tl_dec;
    logic [BW-1:0]               len_d, len_q, note_q, code;
    logic [CW-1:0]               next_idx;
    logic                        sound;

    assign adv_out    = !r_out_vld || o_out.ready;
    assign adv_s2     = !r_s2_vld || adv_out;
    assign adv_s1     = !r_s1_vld || adv_s2;
    assign step       = r_s1_vld && adv_s2;
    assign i_in.ready = adv_s1;

    // A note that has just been loaded takes its length from the store read
    // issued by the previous transaction.
    assign len_d  = r_len_vld_q ? len_q : '0;
    assign tl_eff = r_tl_pend ? (TW'(r_beat_ms) * TW'(len_d)) : r_time_left;
    assign tl_dec = (tl_eff != '0) ? (tl_eff - 1'b1) : tl_eff;
    assign next_idx = CW'(r_play_idx) + 1'b1;

    always_comb begin
        n_load_idx   = r_load_idx;
        n_mel_len    = r_mel_len;
        n_play_idx   = r_play_idx;
        n_active     = r_active;
        n_load_notes = r_load_notes;
        n_load_lens  = r_load_lens;
        n_beat_pend  = r_beat_pend;
        n_beat_ms    = r_beat_ms;
        n_time_left  = tl_eff;
        n_in_gap     = r_in_gap;
        n_tl_pend    = 1'b0;
        do_start     = 1'b0;
        do_stop      = 1'b0;
        do_load      = 1'b0;
        adv_note     = 1'b0;
        wr_note      = 1'b0;
        wr_len       = 1'b0;

        case (mlts_pkg::t_req'(r_s1_req))
            mlts_pkg::REQ_BYTE: begin
                case (r_s1_byte)
                    mlts_pkg::CMD_NOTES: begin
                        n_load_notes = 1'b1;
                        n_load_lens  = 1'b0;
                        n_load_idx   = '0;
                    end
                    mlts_pkg::CMD_DURS: begin
                        n_load_notes = 1'b0;
                        n_load_lens  = 1'b1;
                        n_load_idx   = '0;
                    end
                    mlts_pkg::CMD_END: begin
                        n_load_notes = 1'b0;
                        n_load_lens  = 1'b0;
                        n_mel_len    = r_load_idx;
                        n_load_idx   = '0;
                    end
                    mlts_pkg::CMD_PLAY: begin
                        do_start = !r_active;
                    end
                    mlts_pkg::CMD_STOP: begin
                        do_stop = 1'b1;
                    end
                    mlts_pkg::CMD_BEAT: begin
                        n_beat_pend = 1'b1;
                    end
                    default: begin
                        if ((r_load_notes || r_load_lens) &&
                            (r_load_idx < LW'(SEQ_DEPTH))) begin
                            wr_note    = r_load_notes;
                            wr_len     = !r_load_notes;
                            n_load_idx = r_load_idx + 1'b1;
                        end
                        if (r_beat_pend) begin
                            if (r_s1_byte < BW'(mlts_pkg::BEAT_CODES)) begin
                                n_beat_ms = mlts_pkg::beat_of_code(r_s1_byte[2:0]);
                            end
                            n_beat_pend = 1'b0;
                        end
                    end
                endcase
            end
            mlts_pkg::REQ_TICK: begin
                if (r_active) begin
                    n_time_left = tl_dec;
                    if (tl_dec == '0) begin
                        if (!r_in_gap) begin
                            n_in_gap    = 1'b1;
                            n_time_left = TW'(GAP_MS);
                        end else begin
                            adv_note = 1'b1;
                        end
                    end
                end
            end
            mlts_pkg::REQ_BUTTON: begin
                do_stop  = r_active;
                do_start = !r_active;
            end
            default: ;
        endcase

        if (adv_note) begin
            if ((next_idx >= CW'(r_mel_len)) || (next_idx >= CW'(SEQ_DEPTH))) begin
                do_stop = 1'b1;
            end else begin
                n_play_idx = next_idx[AW-1:0];
                do_load    = 1'b1;
            end
        end
        if (do_start && (r_mel_len != '0)) begin
            n_active   = 1'b1;
            n_play_idx = '0;
            do_load    = 1'b1;
        end
        if (do_load) begin
            n_in_gap  = 1'b0;
            n_tl_pend = 1'b1;
        end
        if (do_stop) begin
            n_active    = 1'b0;
            n_play_idx  = '0;
            n_time_left = '0;
            n_in_gap    = 1'b0;
            n_tl_pend   = 1'b0;
        end
    end

    mlts_ram #(
        .WIDTH (BW),
        .DEPTH (SEQ_DEPTH)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (step && wr_note),
        .i_waddr (r_load_idx[AW-1:0]),
        .i_wdata (r_s1_byte),
        .i_re    (step),
        .i_raddr (n_play_idx),
        .o_rdata (note_q)
    );

    mlts_ram #(
        .WIDTH (BW),
        .DEPTH (SEQ_DEPTH)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (step && wr_len),
        .i_waddr (r_load_idx[AW-1:0]),
        .i_wdata (r_s1_byte),
        .i_re    (step),
        .i_raddr (n_play_idx),
        .o_rdata (len_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_load_idx   <= '0;
            r_mel_len    <= '0;
            r_play_idx   <= '0;
            r_active     <= 1'b0;
            r_load_notes <= 1'b0;
            r_load_lens  <= 1'b0;
            r_beat_pend  <= 1'b0;
            r_beat_ms    <= mlts_pkg::BEAT_RESET;
            r_time_left  <= '0;
            r_in_gap     <= 1'b0;
            r_tl_pend    <= 1'b0;
            r_note_vld   <= '0;
            r_len_vld    <= '0;
            r_len_vld_q  <= 1'b0;
        end else begin
            if (adv_s1) begin
                r_s1_vld <= i_in.valid;
            end
            if (adv_s2) begin
                r_s2_vld <= step;
            end
            if (adv_out) begin
                r_out_vld <= r_s2_vld;
            end
            if (step) begin
                r_load_idx   <= n_load_idx;
                r_mel_len    <= n_mel_len;
                r_play_idx   <= n_play_idx;
                r_active     <= n_active;
                r_load_notes <= n_load_notes;
                r_load_lens  <= n_load_lens;
                r_beat_pend  <= n_beat_pend;
                r_beat_ms    <= n_beat_ms;
                r_time_left  <= n_time_left;
                r_in_gap     <= n_in_gap;
                r_tl_pend    <= n_tl_pend;
                r_len_vld_q  <= r_len_vld[n_play_idx];
                if (wr_note) begin
                    r_note_vld[r_load_idx[AW-1:0]] <= 1'b1;
                end
                if (wr_len) begin
                    r_len_vld[r_load_idx[AW-1:0]] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s1 && i_in.valid) begin
            r_s1_req  <= i_in.req_type;
            r_s1_byte <= i_in.rx_byte;
        end
        if (step) begin
            r_s2_active   <= n_active;
            r_s2_gap      <= n_in_gap;
            // A note written to the slot now playing is taken from here, not
            // from the store read issued in the same cycle.
            r_s2_byp      <= wr_note && (r_load_idx[AW-1:0] == n_play_idx);
            r_s2_byp_code <= r_s1_byte;
            r_s2_note_vld <= r_note_vld[n_play_idx];
        end
        if (adv_out && r_s2_vld) begin
            r_out_tone_on <= sound;
            r_out_period  <= sound ? mlts_pkg::period_of_code(code[3:0]) : '0;
            r_out_playing <= r_s2_active;
        end
    end

    assign code  = r_s2_byp ? r_s2_byp_code : (r_s2_note_vld ? note_q : '0);
    assign sound = r_s2_active && !r_s2_gap && (code < BW'(mlts_pkg::TONE_COUNT));

    assign o_out.valid       = r_out_vld;
    assign o_out.tone_on     = r_out_tone_on;
    assign o_out.tone_period = r_out_period;
    assign o_out.playing     = r_out_playing;

endmodule

/* rtl/core/mlts_ram.sv */
module mlts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/mlts_checker.sv */
module mlts_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_tone_on,
    input logic [mlts_pkg::PER_W-1:0] i_tone_period,
    input logic                       i_playing
);

    logic [2:0] r_inflight;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(in_acc) - 3'(out_acc);
        end
    end

    // The three stages bound the number of transactions in flight.
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd3)
        else $error("more transactions in flight than pipeline stages");

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == 3'd0) |-> !i_out_valid)
        else $error("result offered without an accepted input");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_tone_on) && $stable(i_tone_period) &&
             $stable(i_playing)))
        else $error("stalled result changed");

    a_tone_needs_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_tone_on) |-> (i_playing && (i_tone_period != '0)))
        else $error("tone sounding outside playback or with zero period");

    a_silent_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_tone_on) |-> (i_tone_period == '0))
        else $error("silent result carries a period");

endmodule

bind melody_loader_and_tone_sequencer mlts_checker u_mlts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_tone_on     (o_out.tone_on),
    .i_tone_period (o_out.tone_period),
    .i_playing     (o_out.playing)
);
